FILE: sv/audio_volume_fader_assert.svh
// assertion macros for the audio volume fader checker
// expects clk_i and rst_ni in the scope where a macro is used
`ifndef AUDIO_VOLUME_FADER_ASSERT_SVH
`define AUDIO_VOLUME_FADER_ASSERT_SVH

// same-cycle implication, checked out of reset
`define AVF_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error("audio volume fader check failed");

// next-cycle implication, checked out of reset
`define AVF_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error("audio volume fader check failed");

`endif

FILE: sv/avf_pkg.sv
// shared constants, types and helpers of the audio volume fader
// no dependencies; used by avf_front, avf_core and audio_volume_fader through scoped names
package avf_pkg;

  localparam int unsigned SAMPLE_W   = 16;
  localparam int unsigned LEVEL_W    = 16;
  localparam int unsigned FRAC_W     = 17;
  localparam int unsigned ACC_W      = 33;
  localparam int unsigned POS_W      = 22;
  localparam int unsigned INC_W      = 32;
  localparam int unsigned KIND_W     = 2;
  localparam int unsigned CFG_IDX_W  = 3;
  localparam int unsigned CFG_DATA_W = 32;

  // input queue between front and core
  localparam int unsigned QUEUE_DEPTH = 2;

  // one root bit per step of the square root
  localparam int unsigned SQRT_STEPS = 17;

  localparam logic [LEVEL_W-1:0] UNITY_Q15 = 16'd32768;
  localparam logic [FRAC_W-1:0]  ONE_Q16   = 17'd65536;
  localparam logic [ACC_W-1:0]   ACC_MAX   = '1;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_CURVE_KIND     = 3'd0;
  localparam logic [CFG_IDX_W-1:0] REG_START_LEVEL    = 3'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TARGET_LEVEL   = 3'd2;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_SAMPLES   = 3'd3;
  localparam logic [CFG_IDX_W-1:0] REG_FADE_INCREMENT = 3'd4;

  // curve codes
  localparam logic [KIND_W-1:0] CURVE_SQRT   = 2'd0;
  localparam logic [KIND_W-1:0] CURVE_LINEAR = 2'd1;
  localparam logic [KIND_W-1:0] CURVE_POW15  = 2'd2;
  localparam logic [KIND_W-1:0] CURVE_SQUARE = 2'd3;

  typedef struct packed {
    logic [KIND_W-1:0]  curve_kind;
    logic [LEVEL_W-1:0] start_level;
    logic [LEVEL_W-1:0] target_level;
    logic [POS_W-1:0]   fade_samples;
    logic [INC_W-1:0]   fade_increment;
  } cfg_t;

  // classified sample: sign and magnitude
  typedef struct packed {
    logic               neg;
    logic [SAMPLE_W-1:0] mag;
  } smp_t;

  function automatic logic [LEVEL_W-1:0] clamp_level(input logic [LEVEL_W-1:0] v);
    return (v > UNITY_Q15) ? UNITY_Q15 : v;
  endfunction

  // level reached at the end of a fade, kept in 0..unity
  function automatic logic [LEVEL_W-1:0] end_level(input logic [LEVEL_W-1:0] base,
                                                   input logic signed [LEVEL_W:0] chg);
    logic signed [LEVEL_W+1:0] s;
    s = $signed({2'b00, base}) + $signed({chg[LEVEL_W], chg});
    if (s < 0) begin
      return '0;
    end else if (s > $signed({2'b00, UNITY_Q15})) begin
      return UNITY_Q15;
    end
    return s[LEVEL_W-1:0];
  endfunction

endpackage

FILE: sv/avf_front.sv
// front of the audio volume fader: accepts samples, splits sign and magnitude
// and holds them in a short queue for the core; uses avf_pkg
module avf_front (
  input  logic                         clk_i,
  input  logic                         rst_ni,
  input  logic                         push_i,
  output logic                         full_o,
  input  logic signed [avf_pkg::SAMPLE_W-1:0] sample_i,
  output logic                         item_valid_o,
  input  logic                         item_ready_i,
  output avf_pkg::smp_t                item_o
);

  localparam int unsigned PTR_W = (avf_pkg::QUEUE_DEPTH > 1) ? $clog2(avf_pkg::QUEUE_DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(avf_pkg::QUEUE_DEPTH + 1);

  avf_pkg::smp_t     mem_q [avf_pkg::QUEUE_DEPTH];
  logic [PTR_W-1:0]  wr_ptr_q, rd_ptr_q;
  logic [CNT_W-1:0]  count_q;
  avf_pkg::smp_t     cls;
  logic              do_push, do_pop;

  // sign and magnitude of the incoming sample
  always_comb begin
    cls.neg = sample_i[avf_pkg::SAMPLE_W-1];
    cls.mag = cls.neg ? (~sample_i + 1'b1) : sample_i;
  end

  assign full_o       = (count_q == CNT_W'(avf_pkg::QUEUE_DEPTH));
  assign item_valid_o = (count_q != '0);
  assign item_o       = mem_q[rd_ptr_q];
  assign do_push      = push_i && !full_o;
  assign do_pop       = item_valid_o && item_ready_i;

  // queue pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PTR_W'(avf_pkg::QUEUE_DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PTR_W'(avf_pkg::QUEUE_DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

  // queue storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= cls;
    end
  end

endmodule

FILE: sv/avf_core.sv
// back of the audio volume fader: fade state, curve evaluation with a
// bit-serial square root, gain and sample products, result register; uses avf_pkg
module avf_core (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  avf_pkg::cfg_t                       cfg_i,
  input  avf_pkg::cfg_t                       cfg_next_i,
  input  logic                                restart_i,
  input  logic                                item_valid_i,
  output logic                                item_ready_o,
  input  avf_pkg::smp_t                       item_i,
  output logic                                empty_o,
  input  logic                                pop_i,
  output logic signed [avf_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [avf_pkg::LEVEL_W-1:0]         applied_gain_o,
  output logic                                fading_o
);

  localparam int unsigned CNT_W = $clog2(avf_pkg::SQRT_STEPS);
  localparam int unsigned LW    = avf_pkg::LEVEL_W;
  localparam int unsigned FW    = avf_pkg::FRAC_W;
  localparam int unsigned SW    = avf_pkg::SAMPLE_W;

  localparam logic [2:0] ST_IDLE   = 3'd0;
  localparam logic [2:0] ST_SQRT   = 3'd1;
  localparam logic [2:0] ST_SHAPE  = 3'd2;
  localparam logic [2:0] ST_FMUL   = 3'd3;
  localparam logic [2:0] ST_GAIN   = 3'd4;
  localparam logic [2:0] ST_OUTMUL = 3'd5;
  localparam logic [2:0] ST_DONE   = 3'd6;

  // fade state
  logic [LW-1:0]                base_q;
  logic signed [LW:0]           lc_q;
  logic [avf_pkg::POS_W-1:0]    pos_q;
  logic [avf_pkg::ACC_W-1:0]    acc_q;
  logic                         active_q;

  // sequencer and datapath registers
  logic [2:0]                   st_q;
  logic [CNT_W-1:0]             cnt_q;
  logic                         neg_q;
  logic [SW-1:0]                mag_q;
  logic [FW-1:0]                u_q;
  logic [FW-1:0]                root_q;
  logic [FW:0]                  rem_q;
  logic [2*FW-1:0]              rad_q;
  logic [FW-1:0]                shp_q;
  logic [FW-1:0]                dlt_q;
  logic [LW-1:0]                gain_q;
  logic                         ramp_q;
  logic [2*SW-1:0]              prod_q;

  // result register
  logic                         out_valid_q;
  logic [SW-1:0]                out_sample_q;
  logic [LW-1:0]                out_gain_q;
  logic                         out_fading_q;

  logic                         ramping, rising, take, load_out, sqrt_last;
  logic [FW-1:0]                xw, x_val, u_d, f_val, sqrt_root_d, mul_b;
  logic [FW+2:0]                rem_sh, trial;
  logic                         sqrt_ge;
  logic [FW:0]                  sqrt_rem_d;
  logic [2*FW-1:0]              shape_p;
  logic signed [LW:0]           lc_neg;
  logic [LW-1:0]                lc_mag, end_lvl;
  logic [2*FW-2:0]              fmul_p;
  logic signed [LW+2:0]         g_sum;
  logic [LW-1:0]                gain_ramp;
  logic [avf_pkg::POS_W-1:0]    pos_inc;
  logic [avf_pkg::ACC_W:0]      acc_sum;
  logic [avf_pkg::ACC_W-1:0]    acc_next;
  logic [SW-1:0]                q_mag, res;

  // fraction and curve input
  always_comb begin
    ramping = active_q && (pos_q < cfg_i.fade_samples);
    rising  = (lc_q > 0);
    xw      = acc_q[avf_pkg::ACC_W-1:16];
    x_val   = (xw > avf_pkg::ONE_Q16) ? avf_pkg::ONE_Q16 : xw;
    u_d     = rising ? x_val : (avf_pkg::ONE_Q16 - x_val);
    end_lvl = avf_pkg::end_level(base_q, lc_q);
  end

  // one restoring square root step
  always_comb begin
    rem_sh      = {rem_q, rad_q[2*FW-1:2*FW-2]};
    trial       = {1'b0, root_q, 2'b01};
    sqrt_ge     = (rem_sh >= trial);
    sqrt_rem_d  = sqrt_ge ? (FW+1)'(rem_sh - trial) : (FW+1)'(rem_sh);
    sqrt_root_d = {root_q[FW-2:0], sqrt_ge};
    sqrt_last   = (cnt_q == CNT_W'(avf_pkg::SQRT_STEPS - 1));
  end

  // curve products and gain
  always_comb begin
    mul_b     = (cfg_i.curve_kind == avf_pkg::CURVE_SQUARE) ? u_q : root_q;
    shape_p   = {{FW{1'b0}}, u_q} * {{FW{1'b0}}, mul_b};
    f_val     = rising ? shp_q : (avf_pkg::ONE_Q16 - shp_q);
    lc_neg    = -lc_q;
    lc_mag    = lc_q[LW] ? lc_neg[LW-1:0] : lc_q[LW-1:0];
    fmul_p    = {{FW{1'b0}}, lc_mag} * {{LW{1'b0}}, f_val};
    g_sum     = lc_q[LW] ? ($signed({3'b000, base_q}) - $signed({2'b00, dlt_q}))
                         : ($signed({3'b000, base_q}) + $signed({2'b00, dlt_q}));
    if (g_sum < 0) begin
      gain_ramp = '0;
    end else if (g_sum > $signed({3'b000, avf_pkg::UNITY_Q15})) begin
      gain_ramp = avf_pkg::UNITY_Q15;
    end else begin
      gain_ramp = g_sum[LW-1:0];
    end
    pos_inc  = pos_q + 1'b1;
    acc_sum  = {1'b0, acc_q} + {2'b00, cfg_i.fade_increment};
    acc_next = acc_sum[avf_pkg::ACC_W] ? avf_pkg::ACC_MAX : acc_sum[avf_pkg::ACC_W-1:0];
  end

  // signed result of the sample product
  always_comb begin
    q_mag = prod_q[2*SW-2:SW-1];
    res   = neg_q ? (~q_mag + 1'b1) : q_mag;
  end

  assign item_ready_o = (st_q == ST_IDLE);
  assign take         = item_ready_o && item_valid_i;
  assign load_out     = (st_q == ST_DONE) && (!out_valid_q || pop_i);

  // sequencer, fade state and result valid
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= ST_IDLE;
      cnt_q       <= '0;
      base_q      <= avf_pkg::UNITY_Q15;
      lc_q        <= '0;
      pos_q       <= '0;
      acc_q       <= '0;
      active_q    <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      // result handoff
      if (load_out) begin
        out_valid_q <= 1'b1;
      end else if (pop_i) begin
        out_valid_q <= 1'b0;
      end

      // fade state: restart on a register write, step per ramped sample
      if (restart_i) begin
        base_q   <= avf_pkg::clamp_level(cfg_next_i.start_level);
        lc_q     <= $signed({1'b0, avf_pkg::clamp_level(cfg_next_i.target_level)})
                  - $signed({1'b0, avf_pkg::clamp_level(cfg_next_i.start_level)});
        pos_q    <= '0;
        acc_q    <= '0;
        active_q <= (cfg_next_i.fade_samples != '0);
      end else if (take && !ramping && active_q) begin
        base_q   <= end_lvl;
        lc_q     <= '0;
        active_q <= 1'b0;
      end else if (st_q == ST_GAIN && ramp_q) begin
        pos_q <= pos_inc;
        acc_q <= acc_next;
        if (pos_inc >= cfg_i.fade_samples) begin
          base_q   <= end_lvl;
          lc_q     <= '0;
          active_q <= 1'b0;
        end
      end

      // sequencer
      unique case (st_q)
        ST_IDLE: begin
          cnt_q <= '0;
          if (take) begin
            if (!ramping) begin
              st_q <= ST_OUTMUL;
            end else begin
              unique case (cfg_i.curve_kind)
                avf_pkg::CURVE_LINEAR: st_q <= ST_FMUL;
                avf_pkg::CURVE_SQUARE: st_q <= ST_SHAPE;
                default:               st_q <= ST_SQRT;
              endcase
            end
          end
        end
        ST_SQRT: begin
          cnt_q <= cnt_q + 1'b1;
          if (sqrt_last) begin
            st_q <= (cfg_i.curve_kind == avf_pkg::CURVE_SQRT) ? ST_FMUL : ST_SHAPE;
          end
        end
        ST_SHAPE:  st_q <= ST_FMUL;
        ST_FMUL:   st_q <= ST_GAIN;
        ST_GAIN:   st_q <= ST_OUTMUL;
        ST_OUTMUL: st_q <= ST_DONE;
        ST_DONE: begin
          if (load_out) begin
            st_q <= ST_IDLE;
          end
        end
        default: st_q <= ST_IDLE;
      endcase
    end
  end

  // datapath registers
  always_ff @(posedge clk_i) begin
    unique case (st_q)
      ST_IDLE: begin
        if (take) begin
          neg_q  <= item_i.neg;
          mag_q  <= item_i.mag;
          u_q    <= u_d;
          ramp_q <= ramping;
          root_q <= '0;
          rem_q  <= '0;
          rad_q  <= {u_d, 16'h0000, 1'b0} >> 1;
          shp_q  <= u_d;
          gain_q <= active_q ? end_lvl : base_q;
        end
      end
      ST_SQRT: begin
        root_q <= sqrt_root_d;
        rem_q  <= sqrt_rem_d;
        rad_q  <= {rad_q[2*FW-3:0], 2'b00};
        shp_q  <= sqrt_root_d;
      end
      ST_SHAPE: begin
        shp_q <= shape_p[2*FW-2:16];
      end
      ST_FMUL: begin
        dlt_q <= fmul_p[2*FW-2:16];
      end
      ST_GAIN: begin
        gain_q <= gain_ramp;
      end
      ST_OUTMUL: begin
        prod_q <= {{SW{1'b0}}, mag_q} * {{LW{1'b0}}, gain_q};
      end
      ST_DONE: begin
        if (load_out) begin
          out_sample_q <= res;
          out_gain_q   <= gain_q;
          out_fading_q <= ramp_q;
        end
      end
      default: begin
      end
    endcase
  end

  assign empty_o        = !out_valid_q;
  assign sample_out_o   = out_sample_q;
  assign applied_gain_o = out_gain_q;
  assign fading_o       = out_fading_q;

endmodule

FILE: sv/audio_volume_fader.sv
// audio volume fader: gain ramp applied to a stream of signed 16-bit samples
// channels: samples enter through push/full and leave through empty/pop, each
//   result carrying the scaled sample, the gain used and a ramp flag
// configuration: cfg_we_i writes cfg_idx_i at the clock edge, no wait state;
//   any write to a listed register restarts the fade from the start level
// path from push to empty falling, nothing ahead: queue, then OUTMUL, DONE
//   at a steady gain; FMUL, GAIN first on a linear ramp; SHAPE before FMUL
//   on a square ramp; SQRT steps before FMUL on a square-root ramp and
//   before SHAPE on a power 1.5 ramp; the square-root unit resolves one
//   root bit per cycle; the core takes no sample until the last is loaded
// a two-entry input queue and a result register keep the sides apart: new
//   samples are taken while a finished result waits to be popped
// when the receiver stalls, the result holds, the core stops in its last
//   state and the input queue fills until full is raised
// reset: queues empty, unity gain, no fade; data registers are not reset
// depends on avf_pkg, avf_front and avf_core
module audio_volume_fader (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [avf_pkg::CFG_IDX_W-1:0]       cfg_idx_i,
  input  logic [avf_pkg::CFG_DATA_W-1:0]      cfg_wdata_i,
  input  logic                                push,
  output logic                                full,
  input  logic signed [avf_pkg::SAMPLE_W-1:0] sample_in_i,
  output logic                                empty,
  input  logic                                pop,
  output logic signed [avf_pkg::SAMPLE_W-1:0] sample_out_o,
  output logic [avf_pkg::LEVEL_W-1:0]         applied_gain_o,
  output logic                                fading_o
);

  avf_pkg::cfg_t cfg_q, cfg_d;
  logic          restart;
  logic          item_valid, item_ready;
  avf_pkg::smp_t item;

  // register write decode
  always_comb begin
    cfg_d   = cfg_q;
    restart = 1'b0;
    if (cfg_we_i) begin
      unique case (cfg_idx_i)
        avf_pkg::REG_CURVE_KIND: begin
          cfg_d.curve_kind = cfg_wdata_i[avf_pkg::KIND_W-1:0];
          restart          = 1'b1;
        end
        avf_pkg::REG_START_LEVEL: begin
          cfg_d.start_level = cfg_wdata_i[avf_pkg::LEVEL_W-1:0];
          restart           = 1'b1;
        end
        avf_pkg::REG_TARGET_LEVEL: begin
          cfg_d.target_level = cfg_wdata_i[avf_pkg::LEVEL_W-1:0];
          restart            = 1'b1;
        end
        avf_pkg::REG_FADE_SAMPLES: begin
          cfg_d.fade_samples = cfg_wdata_i[avf_pkg::POS_W-1:0];
          restart            = 1'b1;
        end
        avf_pkg::REG_FADE_INCREMENT: begin
          cfg_d.fade_increment = cfg_wdata_i[avf_pkg::INC_W-1:0];
          restart              = 1'b1;
        end
        default: begin
        end
      endcase
    end
  end

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.curve_kind     <= avf_pkg::CURVE_SQRT;
      cfg_q.start_level    <= avf_pkg::UNITY_Q15;
      cfg_q.target_level   <= avf_pkg::UNITY_Q15;
      cfg_q.fade_samples   <= '0;
      cfg_q.fade_increment <= '0;
    end else begin
      cfg_q <= cfg_d;
    end
  end

  // sample intake
  avf_front u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .push_i       (push),
    .full_o       (full),
    .sample_i     (sample_in_i),
    .item_valid_o (item_valid),
    .item_ready_i (item_ready),
    .item_o       (item)
  );

  // gain engine and result register
  avf_core u_core (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_i          (cfg_q),
    .cfg_next_i     (cfg_d),
    .restart_i      (restart),
    .item_valid_i   (item_valid),
    .item_ready_o   (item_ready),
    .item_i         (item),
    .empty_o        (empty),
    .pop_i          (pop),
    .sample_out_o   (sample_out_o),
    .applied_gain_o (applied_gain_o),
    .fading_o       (fading_o)
  );

endmodule

FILE: sv/avf_checker.sv
// port-level checks of the audio volume fader, bound to the top level
// depends on audio_volume_fader_assert.svh and audio_volume_fader
`include "audio_volume_fader_assert.svh"

module avf_checker (
  input logic               clk_i,
  input logic               rst_ni,
  input logic               empty,
  input logic               pop,
  input logic signed [15:0] sample_out_o,
  input logic [15:0]        applied_gain_o,
  input logic               fading_o
);

  // gain never exceeds unity
  `AVF_ASSERT_NOW(a_gain_range, !empty, applied_gain_o <= 16'd32768)

  // zero gain mutes the sample
  `AVF_ASSERT_NOW(a_mute, !empty && (applied_gain_o == 16'd0), sample_out_o == 16'sd0)

  // a result not taken stays put
  `AVF_ASSERT_NEXT(a_hold, !empty && !pop, !empty && $stable(sample_out_o) && $stable(applied_gain_o) && $stable(fading_o))

endmodule

bind audio_volume_fader avf_checker u_avf_checker (.*);
